// ----- sv/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and codes of the first-fit heap allocator
// Request and response words, the chunk table entry and the status and
// register index codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int LEN_W = 13;
    localparam int OFS_W = 12;
    localparam int OVH_W = 7;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_BAD_OFFSET = 3'd2;
    localparam logic [2:0] ST_FIT_RULE   = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_HEAP_WORDS     = 2'd0;
    localparam logic [1:0] REG_OVERHEAD_WORDS = 2'd1;
    localparam logic [1:0] REG_STRICT_FIT     = 2'd2;

    typedef struct packed {
        logic             kind;
        logic [LEN_W-1:0] size_words;
        logic [OFS_W-1:0] offset_words;
    } ffha_req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [OFS_W-1:0] payload_offset;
    } ffha_rsp_t;

    typedef struct packed {
        logic             used;
        logic [LEN_W-1:0] len;
    } chunk_t;

    typedef struct packed {
        logic             fit;
        logic             short_rem;
        logic             split;
        logic [LEN_W-1:0] rem;
    } fit_t;

endpackage

// ----- sv/ffha_fit_unit.sv -----
// ----------------------------------------------------------------------------
// ffha_fit_unit: fit test for one chunk
// Compares a chunk against the requested length and flags a nonzero remainder
// as short (<= overhead) and as large enough to split off (>= overhead).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffha_fit_unit
    import ffha_pkg::*;
(
    input  chunk_t             entry,
    input  logic [LEN_W:0]     need,
    input  logic [OVH_W-1:0]   overhead,
    output fit_t               result
);

    logic [LEN_W-1:0] rem;
    logic             rem_nz;

    assign rem    = entry.len - need[LEN_W-1:0];
    assign rem_nz = (rem != '0);

    always_comb
    begin
        result.fit       = !entry.used && ({1'b0, entry.len} >= need);
        result.rem       = rem;
        result.short_rem = rem_nz && (rem <= LEN_W'(overhead));
        result.split     = rem_nz && (rem >= LEN_W'(overhead));
    end

endmodule

// ----- sv/first_fit_heap_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core: first-fit word heap allocator
// Keeps an address-ordered chunk table in a single-port-write memory and
// serves allocate and free commands with a sequencer around one fit unit.
// ----------------------------------------------------------------------------
//  Channel   Signals                                    Flow
//  command   start, busy, req                           accepted when start and !busy
//  result    done, rsp                                  one cycle, cannot be stalled
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  written when valid and ready
//
// An allocate scans the table one chunk per cycle; on a split, the later chunks
// move up (S_INS) and then the tail is written (S_IFIN). A free scans the same
// way up to its chunk, merges it with free neighbours (S_FNXT) and moves the
// later chunks down (S_RM). A zero size or a short offset is answered from
// S_IDLE without a scan. After reset and each heap_words write the block is busy
// while it rewrites the first table entry. The result strobe cannot be held off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int HEAP_DEPTH = 4096,
    parameter int MAX_CHUNKS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ffha_req_t        req,
    output logic             done,
    output ffha_rsp_t        rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [LEN_W-1:0] cfg_data
);

    localparam int IW       = $clog2(MAX_CHUNKS);
    localparam int NW       = $clog2(MAX_CHUNKS + 1);
    localparam int HEAP_CAP = (HEAP_DEPTH > 8191) ? 8191 : HEAP_DEPTH;
    localparam int HEAP_RST = (HEAP_DEPTH < 4096) ? HEAP_DEPTH : 4096;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_IFIN = 3'd3;
    localparam logic [2:0] S_FNXT = 3'd4;
    localparam logic [2:0] S_RM   = 3'd5;

    // Chunk table
    chunk_t mem [MAX_CHUNKS];
    chunk_t rdata_reg;
    logic [IW-1:0] rd_addr;
    logic          we;
    logic [IW-1:0] wa;
    chunk_t        wd;

    // Configuration
    logic [LEN_W-1:0] heap_words_reg, heap_words_next;
    logic [OVH_W-1:0] ovh_reg, ovh_next;
    logic             strict_reg, strict_next;
    logic             init_pend_reg, init_pend_next;

    // Sequencer
    logic [2:0]       state_reg, state_next;
    logic [NW-1:0]    count_reg, count_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    src_reg, src_next;
    logic [1:0]       d_reg, d_next;
    logic [LEN_W-1:0] acc_reg, acc_next;
    logic             kind_reg, kind_next;
    logic [LEN_W:0]   need_reg, need_next;
    logic [OFS_W-1:0] target_reg, target_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] merged_reg, merged_next;
    logic             pf_reg, pf_next;
    chunk_t           prev_reg, prev_next;
    logic             done_reg, done_next;
    ffha_rsp_t        rsp_reg, rsp_next;

    fit_t             fit;
    logic             last;
    logic             pf;
    logic             nf;
    logic [1:0]       n_rm;
    logic [NW:0]      src1;
    logic [LEN_W-1:0] pay_calc;
    logic [LEN_W-1:0] clamp_heap;

    ffha_fit_unit u_fit
    (
        .entry    (rdata_reg),
        .need     (need_reg),
        .overhead (ovh_reg),
        .result   (fit)
    );

    assign busy      = init_pend_reg || (state_reg != S_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    assign last     = (NW'(idx_reg) == (count_reg - NW'(1)));
    assign pay_calc = acc_reg + LEN_W'(ovh_reg);
    assign pf       = (idx_reg != '0) && !prev_reg.used;
    assign nf       = !last && !rdata_reg.used;
    assign n_rm     = {1'b0, pf_reg} + {1'b0, nf};
    assign src1     = (NW + 1)'(idx_reg) + (NW + 1)'(1) + (NW + 1)'(nf);

    always_comb
    begin
        if (cfg_data == '0)
        begin
            clamp_heap = LEN_W'(1);
        end
        else if (32'(cfg_data) > HEAP_CAP)
        begin
            clamp_heap = LEN_W'(HEAP_CAP);
        end
        else
        begin
            clamp_heap = cfg_data;
        end
    end

    always_comb
    begin
        heap_words_next = heap_words_reg;
        ovh_next        = ovh_reg;
        strict_next     = strict_reg;
        init_pend_next  = 1'b0;
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        src_next        = src_reg;
        d_next          = d_reg;
        acc_next        = acc_reg;
        kind_next       = kind_reg;
        need_next       = need_reg;
        target_next     = target_reg;
        rem_next        = rem_reg;
        merged_next     = merged_reg;
        pf_next         = pf_reg;
        prev_next       = prev_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        rd_addr         = idx_reg + IW'(1);
        we              = 1'b0;
        wa              = idx_reg;
        wd              = rdata_reg;

        if (init_pend_reg)
        begin
            we = 1'b1;
            wa = '0;
            wd = '{used: 1'b0, len: heap_words_reg};
        end

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                if (start && !busy)
                begin
                    idx_next    = '0;
                    acc_next    = '0;
                    kind_next   = req.kind;
                    need_next   = {1'b0, req.size_words} + (LEN_W + 1)'(ovh_reg);
                    target_next = req.offset_words - OFS_W'(ovh_reg);
                    rsp_next    = '{status: ST_OK, payload_offset: '0};
                    if (req.kind == KIND_ALLOC)
                    begin
                        if (req.size_words == '0)
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = ST_NO_SPACE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (req.offset_words < OFS_W'(ovh_reg))
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = ST_BAD_OFFSET;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                prev_next = rdata_reg;
                if (kind_reg == KIND_ALLOC)
                begin
                    if (fit.fit)
                    begin
                        if (strict_reg && fit.short_rem)
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = ST_FIT_RULE;
                            state_next      = S_IDLE;
                        end
                        else if (fit.split)
                        begin
                            if (count_reg >= NW'(MAX_CHUNKS))
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = ST_TABLE_FULL;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                // The head keeps the request; the tail is
                                // written once the later chunks have moved up.
                                we       = 1'b1;
                                wa       = idx_reg;
                                wd       = '{used: 1'b1, len: need_reg[LEN_W-1:0]};
                                rem_next = fit.rem;
                                if (last)
                                begin
                                    state_next = S_IFIN;
                                end
                                else
                                begin
                                    src_next   = IW'(count_reg - NW'(1));
                                    rd_addr    = IW'(count_reg - NW'(1));
                                    state_next = S_INS;
                                end
                            end
                        end
                        else
                        begin
                            we         = 1'b1;
                            wa         = idx_reg;
                            wd         = '{used: 1'b1, len: rdata_reg.len};
                            done_next  = 1'b1;
                            rsp_next   = '{status: ST_OK, payload_offset: pay_calc[OFS_W-1:0]};
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        acc_next = acc_reg + rdata_reg.len;
                        if (last)
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = ST_NO_SPACE;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + IW'(1);
                        end
                    end
                end
                else
                begin
                    if (acc_reg == {1'b0, target_reg})
                    begin
                        if (!rdata_reg.used)
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = ST_BAD_OFFSET;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            // The next entry is already being read for the merge.
                            pf_next     = pf;
                            merged_next = pf ? (prev_reg.len + rdata_reg.len) : rdata_reg.len;
                            state_next  = S_FNXT;
                        end
                    end
                    else if (acc_reg > {1'b0, target_reg})
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = ST_BAD_OFFSET;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        acc_next = acc_reg + rdata_reg.len;
                        if (last)
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = ST_BAD_OFFSET;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + IW'(1);
                        end
                    end
                end
            end

            S_INS:
            begin
                we = 1'b1;
                wa = src_reg + IW'(1);
                wd = rdata_reg;
                if (src_reg == (idx_reg + IW'(1)))
                begin
                    state_next = S_IFIN;
                end
                else
                begin
                    src_next = src_reg - IW'(1);
                    rd_addr  = src_reg - IW'(1);
                end
            end

            S_IFIN:
            begin
                we         = 1'b1;
                wa         = idx_reg + IW'(1);
                wd         = '{used: 1'b0, len: rem_reg};
                count_next = count_reg + NW'(1);
                done_next  = 1'b1;
                rsp_next   = '{status: ST_OK, payload_offset: pay_calc[OFS_W-1:0]};
                state_next = S_IDLE;
            end

            S_FNXT:
            begin
                we     = 1'b1;
                wa     = pf_reg ? (idx_reg - IW'(1)) : idx_reg;
                wd     = '{used: 1'b0,
                           len: merged_reg + (nf ? rdata_reg.len : LEN_W'(0))};
                d_next = n_rm;
                if (n_rm == 2'd0)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{status: ST_OK, payload_offset: '0};
                    state_next = S_IDLE;
                end
                else if (src1 < {1'b0, count_reg})
                begin
                    src_next   = IW'(src1);
                    rd_addr    = IW'(src1);
                    state_next = S_RM;
                end
                else
                begin
                    count_next = count_reg - NW'(n_rm);
                    done_next  = 1'b1;
                    rsp_next   = '{status: ST_OK, payload_offset: '0};
                    state_next = S_IDLE;
                end
            end

            S_RM:
            begin
                we = 1'b1;
                wa = src_reg - IW'(d_reg);
                wd = rdata_reg;
                if (NW'(src_reg) == (count_reg - NW'(1)))
                begin
                    count_next = count_reg - NW'(d_reg);
                    done_next  = 1'b1;
                    rsp_next   = '{status: ST_OK, payload_offset: '0};
                    state_next = S_IDLE;
                end
                else
                begin
                    src_next = src_reg + IW'(1);
                    rd_addr  = src_reg + IW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HEAP_WORDS:
                begin
                    heap_words_next = clamp_heap;
                    count_next      = NW'(1);
                    init_pend_next  = 1'b1;
                end
                REG_OVERHEAD_WORDS:
                begin
                    ovh_next = cfg_data[OVH_W-1:0];
                end
                REG_STRICT_FIT:
                begin
                    strict_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_words_reg <= LEN_W'(HEAP_RST);
            ovh_reg        <= OVH_W'(1);
            strict_reg     <= 1'b0;
            init_pend_reg  <= 1'b1;
            state_reg      <= S_IDLE;
            count_reg      <= NW'(1);
            done_reg       <= 1'b0;
        end
        else
        begin
            heap_words_reg <= heap_words_next;
            ovh_reg        <= ovh_next;
            strict_reg     <= strict_next;
            init_pend_reg  <= init_pend_next;
            state_reg      <= state_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        src_reg    <= src_next;
        d_reg      <= d_next;
        acc_reg    <= acc_next;
        kind_reg   <= kind_next;
        need_reg   <= need_next;
        target_reg <= target_next;
        rem_reg    <= rem_next;
        merged_reg <= merged_next;
        pf_reg     <= pf_next;
        prev_reg   <= prev_next;
        rsp_reg    <= rsp_next;
    end

    // The table always holds at least one chunk and never more than it can.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (32'(count_reg) <= MAX_CHUNKS))
        else $error("chunk count out of range");

    // A result word only follows an accepted command or a sequencer step.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past((state_reg != S_IDLE) || (start && !busy)))
        else $error("result without a command");

    // Only a successful allocate carries a payload offset.
    a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.payload_offset != '0)) |-> (rsp.status == ST_OK))
        else $error("payload offset on a failed request");

endmodule
